// File: src/rcp3by2_pkg.sv
// shared types and constants for the 3-by-2 reciprocal pipeline
package rcp3by2_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;
  localparam int unsigned DivStages = HalfW;
  localparam int unsigned TailStages = 10;
  localparam int unsigned Latency = DivStages + TailStages;
  localparam logic [HalfW-1:0] HalfOnes = 16'hFFFF;

  typedef struct packed {
    logic [WordW-1:0] divisor_high;
    logic [WordW-1:0] divisor_low;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] reciprocal;
    logic             not_normalized;
  } out_t;

endpackage

// File: src/reciprocal_3by2_normalized.sv
// top level: pipelined 3-by-2 reciprocal of a normalized two-word divisor
//
// input: an item is taken on each rising edge with start high and busy low.
// busy is always low, so a new divisor may enter every cycle.
// in_data carries divisor_high and divisor_low.
// output: out_valid is high for one cycle with out_data holding reciprocal
// and not_normalized for the item; results leave in entry order.
// the pipeline has 16 divider stages, one quotient bit each, then ten
// stages of corrections and the 32x32 fold-in multiply.
// throughput is one item per cycle.
// the receiver cannot stall; every result appears exactly once.
// a divisor whose top bit is clear yields not_normalized high and zero.
// reset clears all valid bits; items in flight are dropped.
module reciprocal_3by2_normalized (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rcp3by2_pkg::in_t  in_data,
  output logic              out_valid,
  output rcp3by2_pkg::out_t out_data
);

  localparam int unsigned W = rcp3by2_pkg::WordW;
  localparam int unsigned H = rcp3by2_pkg::HalfW;

  logic             dv_v;
  rcp3by2_pkg::in_t dv_it;
  logic [H-1:0]     dv_q, dv_r;

  assign busy = 1'b0;

  rcp3by2_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_item   (in_data),
    .out_valid (dv_v),
    .out_item  (dv_it),
    .out_quo   (dv_q),
    .out_rem   (dv_r)
  );

  // stage a
  logic a_v_r; rcp3by2_pkg::in_t a_it_r;
  logic [W-1:0] a_rem_r, a_p_r; logic [H-1:0] a_qh_r;
  // stage b
  logic b_v_r; rcp3by2_pkg::in_t b_it_r;
  logic [W-1:0] b_rem_r; logic [H-1:0] b_qh_r;
  logic [W-1:0] b_rem_nxt; logic [H-1:0] b_qh_nxt;
  // stage c
  logic c_v_r; rcp3by2_pkg::in_t c_it_r;
  logic [W-1:0] c_rem_r, c_p_r; logic [H-1:0] c_qh_r;
  // stage d
  logic d_v_r; rcp3by2_pkg::in_t d_it_r;
  logic [W-1:0] d_rsh_r, d_prod_r, d_pcmp_r; logic [H:0] d_ql_r; logic [H-1:0] d_qh_r;
  logic [H:0] d_ql_nxt;
  // stage e
  logic e_v_r; rcp3by2_pkg::in_t e_it_r;
  logic [W-1:0] e_rem_r; logic [H:0] e_ql_r; logic [H-1:0] e_qh_r;
  logic [W-1:0] e_rem_nxt; logic [H:0] e_ql_nxt;
  // stage f
  logic f_v_r; rcp3by2_pkg::in_t f_it_r;
  logic [W-1:0] f_m_r, f_rem_r;
  logic [W-1:0] f_m_nxt, f_rem_nxt;
  // stage g
  logic g_v_r; rcp3by2_pkg::in_t g_it_r;
  logic [W-1:0] g_m_r, g_rem_r; logic g_c_r;
  logic [W:0] g_sum;
  // stage h
  logic h_v_r; rcp3by2_pkg::in_t h_it_r;
  logic [W-1:0] h_m_r, h_m0_r, h_rem_r;
  logic [W-1:0] h_m_nxt, h_rem_nxt;
  // stage i
  logic i_v_r; rcp3by2_pkg::in_t i_it_r;
  logic [W-1:0] i_m_r, i_m0_r, i_rem_r; logic [2*W-1:0] i_prod_r;
  // output
  logic out_v_r; rcp3by2_pkg::out_t out_r, out_nxt;
  logic [W:0] j_sum; logic [W-1:0] j_m;

  always_comb begin
    logic [W-1:0] rem, u1;
    logic [H-1:0] qh;
    u1  = a_it_r.divisor_high;
    rem = a_rem_r;
    qh  = a_qh_r;
    if (rem < a_p_r) begin
      qh  = qh - 1'b1;
      rem = rem + u1;
      if (rem >= u1 && rem < a_p_r) begin
        qh  = qh - 1'b1;
        rem = rem + u1;
      end
    end
    b_rem_nxt = rem - a_p_r;
    b_qh_nxt  = qh;
  end

  assign d_ql_nxt = {1'b0, c_p_r[W-1:H]} + 1'b1;

  always_comb begin
    e_rem_nxt = d_rsh_r - d_prod_r;
    e_ql_nxt  = d_ql_r;
    if (e_rem_nxt >= d_pcmp_r) begin
      e_ql_nxt  = d_ql_r - 1'b1;
      e_rem_nxt = e_rem_nxt + d_it_r.divisor_high;
    end
  end

  always_comb begin
    f_m_nxt   = {e_qh_r, {H{1'b0}}} + W'(e_ql_r);
    f_rem_nxt = e_rem_r;
    if (e_rem_r >= e_it_r.divisor_high) begin
      f_m_nxt   = f_m_nxt + 1'b1;
      f_rem_nxt = e_rem_r - e_it_r.divisor_high;
    end
  end

  assign g_sum = {1'b0, ~f_rem_r} + {1'b0, f_it_r.divisor_low};

  always_comb begin
    h_m_nxt   = g_m_r;
    h_rem_nxt = g_rem_r;
    if (g_c_r) begin
      h_m_nxt = g_m_r - 1'b1;
      if (g_rem_r >= g_it_r.divisor_high) begin
        h_m_nxt   = h_m_nxt - 1'b1;
        h_rem_nxt = h_rem_nxt - g_it_r.divisor_high;
      end
      h_rem_nxt = h_rem_nxt - g_it_r.divisor_high;
    end
  end

  always_comb begin
    j_sum = {1'b0, i_rem_r} + {1'b0, i_prod_r[2*W-1:W]};
    j_m   = i_m_r;
    if (j_sum[W]) begin
      j_m = i_m_r - 1'b1;
      if (j_sum[W-1:0] > i_it_r.divisor_high ||
          (j_sum[W-1:0] == i_it_r.divisor_high && i_prod_r[W-1:0] > i_it_r.divisor_low)) begin
        j_m = j_m - 1'b1;
      end
    end
    out_nxt.not_normalized = ~i_it_r.divisor_high[W-1];
    if (!i_it_r.divisor_high[W-1]) begin
      out_nxt.reciprocal = '0;
    end else if (i_it_r.divisor_low == '0) begin
      out_nxt.reciprocal = i_m0_r;
    end else begin
      out_nxt.reciprocal = j_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0; b_v_r <= 1'b0; c_v_r <= 1'b0; d_v_r <= 1'b0; e_v_r <= 1'b0;
      f_v_r <= 1'b0; g_v_r <= 1'b0; h_v_r <= 1'b0; i_v_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      a_v_r <= dv_v;  b_v_r <= a_v_r; c_v_r <= b_v_r; d_v_r <= c_v_r; e_v_r <= d_v_r;
      f_v_r <= e_v_r; g_v_r <= f_v_r; h_v_r <= g_v_r; i_v_r <= h_v_r; out_v_r <= i_v_r;
    end
    a_it_r  <= dv_it;
    a_rem_r <= {dv_r, rcp3by2_pkg::HalfOnes};
    a_p_r   <= {{H{1'b0}}, dv_q} * {{H{1'b0}}, dv_it.divisor_high[H-1:0]};
    a_qh_r  <= dv_q;

    b_it_r  <= a_it_r;
    b_rem_r <= b_rem_nxt;
    b_qh_r  <= b_qh_nxt;

    c_it_r  <= b_it_r;
    c_rem_r <= b_rem_r;
    c_qh_r  <= b_qh_r;
    c_p_r   <= ({{H{1'b0}}, b_rem_r[W-1:H]} * {{H{1'b0}}, b_qh_r}) + b_rem_r;

    d_it_r   <= c_it_r;
    d_qh_r   <= c_qh_r;
    d_ql_r   <= d_ql_nxt;
    d_rsh_r  <= {c_rem_r[H-1:0], rcp3by2_pkg::HalfOnes};
    d_pcmp_r <= {c_p_r[H-1:0], {H{1'b0}}};
    d_prod_r <= W'(d_ql_nxt * c_it_r.divisor_high);

    e_it_r  <= d_it_r;
    e_qh_r  <= d_qh_r;
    e_ql_r  <= e_ql_nxt;
    e_rem_r <= e_rem_nxt;

    f_it_r  <= e_it_r;
    f_m_r   <= f_m_nxt;
    f_rem_r <= f_rem_nxt;

    g_it_r  <= f_it_r;
    g_m_r   <= f_m_r;
    g_rem_r <= g_sum[W-1:0];
    g_c_r   <= g_sum[W];

    h_it_r  <= g_it_r;
    h_m0_r  <= g_m_r;
    h_m_r   <= h_m_nxt;
    h_rem_r <= h_rem_nxt;

    i_it_r   <= h_it_r;
    i_m0_r   <= h_m0_r;
    i_m_r    <= h_m_r;
    i_rem_r  <= h_rem_r;
    i_prod_r <= h_it_r.divisor_low * h_m_r;

    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: src/rcp3by2_div.sv
// pipelined restoring divider: (~high) / high[31:16], one quotient bit per stage
module rcp3by2_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  rcp3by2_pkg::in_t                      in_item,
  output logic                                  out_valid,
  output rcp3by2_pkg::in_t                      out_item,
  output logic [rcp3by2_pkg::HalfW-1:0]         out_quo,
  output logic [rcp3by2_pkg::HalfW-1:0]         out_rem
);

  localparam int unsigned N = rcp3by2_pkg::DivStages;
  localparam int unsigned W = rcp3by2_pkg::WordW;
  localparam int unsigned H = rcp3by2_pkg::HalfW;

  logic [N-1:0]     vld_r;
  logic [W-1:0]     rem_r   [N];
  logic [H-1:0]     quo_r   [N];
  rcp3by2_pkg::in_t item_r  [N];

  logic [W-1:0]     rem_cur [N];
  logic [H-1:0]     quo_cur [N];
  rcp3by2_pkg::in_t item_cur[N];
  logic [W-1:0]     rem_nxt [N];
  logic [H-1:0]     quo_nxt [N];

  always_comb begin
    rem_cur[0]  = ~in_item.divisor_high;
    quo_cur[0]  = '0;
    item_cur[0] = in_item;
    for (int s = 1; s < N; s++) begin
      rem_cur[s]  = rem_r[s-1];
      quo_cur[s]  = quo_r[s-1];
      item_cur[s] = item_r[s-1];
    end
  end

  always_comb begin
    for (int s = 0; s < N; s++) begin
      logic [W-1:0] shifted;
      shifted = W'(item_cur[s].divisor_high[W-1:H]) << (N-1-s);
      if (rem_cur[s] >= shifted) begin
        rem_nxt[s] = rem_cur[s] - shifted;
        quo_nxt[s] = quo_cur[s] | (H'(1) << (N-1-s));
      end else begin
        rem_nxt[s] = rem_cur[s];
        quo_nxt[s] = quo_cur[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
    for (int s = 0; s < N; s++) begin
      rem_r[s]  <= rem_nxt[s];
      quo_r[s]  <= quo_nxt[s];
      item_r[s] <= item_cur[s];
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_item  = item_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_rem   = rem_r[N-1][H-1:0];

endmodule

// File: src/rcp3by2_chk.sv
// port-level checker for the reciprocal pipeline and its bind
module rcp3by2_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input rcp3by2_pkg::in_t  in_data,
  input logic              out_valid,
  input rcp3by2_pkg::out_t out_data
);

  localparam int unsigned L = rcp3by2_pkg::Latency;

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##L out_valid)
    else $error("item accepted but no result after pipeline latency");

  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.not_normalized == !$past(in_data.divisor_high[31], L))
    else $error("not_normalized does not match the item that entered");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.not_normalized |-> out_data.reciprocal == '0)
    else $error("unnormalized item gave a nonzero reciprocal");

endmodule

bind reciprocal_3by2_normalized rcp3by2_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// File: dv/reciprocal_3by2_normalized_test.sv
// testbench for the pipelined 3-by-2 reciprocal: bit-exact predictor and result scoreboard
`timescale 1ns / 100ps

module reciprocal_3by2_normalized_test;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  rcp3by2_pkg::in_t  in_data;
  logic out_valid;
  rcp3by2_pkg::out_t out_data;

  rcp3by2_pkg::out_t expected_q[$];
  int   mismatch_count;
  int   result_count;
  int   item_count;
  int   unnorm_count;
  int   zero_low_count;
  int   send_idle_pct;
  logic quiet;

  reciprocal_3by2_normalized dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] calc_reciprocal(logic [31:0] u1, logic [31:0] u0);
    logic [31:0] lo16;
    logic [31:0] hi16;
    logic [31:0] nu1;
    logic [31:0] qh;
    logic [31:0] ql;
    logic [31:0] rem;
    logic [31:0] p;
    logic [31:0] m;
    logic [31:0] th;
    logic [31:0] tl;
    logic [63:0] prod;
    lo16 = u1 & 32'h0000FFFF;
    hi16 = u1 >> 16;
    nu1 = ~u1;
    qh = nu1 / hi16;
    rem = ((nu1 - qh * hi16) << 16) | 32'h0000FFFF;
    p = qh * lo16;
    if (rem < p) begin
      qh = qh - 1;
      rem = rem + u1;
      if (rem >= u1 && rem < p) begin
        qh = qh - 1;
        rem = rem + u1;
      end
    end
    rem = rem - p;
    p = (rem >> 16) * qh + rem;
    ql = (p >> 16) + 1;
    rem = (rem << 16) + 32'h0000FFFF - ql * u1;
    if (rem >= (p << 16)) begin
      ql = ql - 1;
      rem = rem + u1;
    end
    m = (qh << 16) + ql;
    if (rem >= u1) begin
      m = m + 1;
      rem = rem - u1;
    end
    if (u0 != 0) begin
      rem = ~rem;
      rem = rem + u0;
      if (rem < u0) begin
        m = m - 1;
        if (rem >= u1) begin
          m = m - 1;
          rem = rem - u1;
        end
        rem = rem - u1;
      end
      prod = {32'b0, u0} * {32'b0, m};
      th = prod[63:32];
      tl = prod[31:0];
      rem = rem + th;
      if (rem < th) begin
        m = m - 1;
        if (rem > u1 || (rem == u1 && tl > u0)) m = m - 1;
      end
    end
    return m;
  endfunction

  function automatic rcp3by2_pkg::out_t predict_result(rcp3by2_pkg::in_t item);
    rcp3by2_pkg::out_t r;
    if (!item.divisor_high[31]) begin
      r.reciprocal = '0;
      r.not_normalized = 1'b1;
    end else begin
      r.reciprocal = calc_reciprocal(item.divisor_high, item.divisor_low);
      r.not_normalized = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("error at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    rcp3by2_pkg::out_t want;
    if (rst_n && out_valid) begin
      result_count++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.reciprocal, 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.reciprocal !== want.reciprocal)
          report_mismatch("reciprocal", out_data.reciprocal, want.reciprocal);
        if (out_data.not_normalized !== want.not_normalized)
          report_mismatch("not_normalized", 32'(out_data.not_normalized),
                          32'(want.not_normalized));
      end
    end
  end

  task automatic send_item(logic [31:0] hi, logic [31:0] lo);
    rcp3by2_pkg::in_t item;
    while (!quiet && send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    item.divisor_high = hi;
    item.divisor_low = lo;
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_result(item));
    item_count++;
    if (!hi[31]) unnorm_count++;
    if (lo == 0) zero_low_count++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    unique case ($urandom_range(5, 0))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return 32'hFFFFFFFF - $urandom_range(15, 0);
      3: return $urandom_range(15, 0);
      4: return 32'h1 << $urandom_range(31, 0);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_item(32'h80000000, 32'h00000000);
    send_item(32'h80000000, 32'h00000001);
    send_item(32'h80000000, 32'hFFFFFFFF);
    send_item(32'hFFFFFFFF, 32'h00000000);
    send_item(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(32'hFFFFFFFF, 32'h00000001);
    send_item(32'h80000001, 32'h00000000);
    send_item(32'h8000FFFF, 32'hFFFFFFFF);
    send_item(32'hFFFF0000, 32'h00000000);
    send_item(32'hFFFF0000, 32'hFFFFFFFF);
    send_item(32'hC0000000, 32'h80000000);
    send_item(32'hAAAAAAAA, 32'h55555555);
    send_item(32'hD5555555, 32'hAAAAAAAA);
    send_item(32'h00000000, 32'h00000000);
    send_item(32'h7FFFFFFF, 32'hFFFFFFFF);
    send_item(32'h00000001, 32'h12345678);
    send_item(32'h80008000, 32'h00010000);
    send_item(32'hFFFFFFFE, 32'hFFFFFFFF);
  endtask

  task automatic test_random(int count);
    logic [31:0] hi;
    logic [31:0] lo;
    for (int i = 0; i < count; i++) begin
      hi = rand_word();
      if ($urandom_range(9, 0) != 0) hi[31] = 1'b1;
      lo = ($urandom_range(7, 0) == 0) ? 32'h0 : rand_word();
      send_item(hi, lo);
    end
  endtask

  task automatic test_pause();
    test_random(20);
    drain();
    test_random(20);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    quiet = 1'b0;
    send_idle_pct = 7;
    mismatch_count = 0;
    result_count = 0;
    item_count = 0;
    unnorm_count = 0;
    zero_low_count = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(280);
    send_idle_pct = 56;
    test_pause();
    test_random(260);
    send_idle_pct = 0;
    test_random(280);
    drain();
    repeat (rcp3by2_pkg::Latency + 10) @(negedge clk);
    $display("sent %0d divisors (%0d unnormalized, %0d with zero low word), checked %0d results",
             item_count, unnorm_count, zero_low_count, result_count);
    $display("sender gaps of 7 and 56 percent, back-to-back traffic and one full drain pause");
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
